// ===== sv/smx_pkg.sv =====
package smx_pkg;

   localparam int DATA_DEPTH  = 64;
   localparam int CALL_DEPTH  = 64;
   localparam int STORE_DEPTH = 256;
   localparam int PROG_DEPTH  = 1024;

   localparam int DATA_AW  = $clog2(DATA_DEPTH);
   localparam int DATA_CW  = $clog2(DATA_DEPTH + 1);
   localparam int CALL_AW  = $clog2(CALL_DEPTH);
   localparam int CALL_CW  = $clog2(CALL_DEPTH + 1);
   localparam int STORE_AW = $clog2(STORE_DEPTH);
   localparam int PC_W     = $clog2(PROG_DEPTH);

   localparam int REQ_W = 40;
   localparam int RSP_W = 56;

   typedef struct packed {
      logic [2:0]  tag;
      logic [31:0] val;
   } cell_type;

   localparam logic [4:0] OP_PUSH = 5'd0;
   localparam logic [4:0] OP_POP  = 5'd1;
   localparam logic [4:0] OP_DUP  = 5'd2;
   localparam logic [4:0] OP_ADD  = 5'd3;
   localparam logic [4:0] OP_SUB  = 5'd4;
   localparam logic [4:0] OP_MUL  = 5'd5;
   localparam logic [4:0] OP_DIV  = 5'd6;
   localparam logic [4:0] OP_JMP  = 5'd7;
   localparam logic [4:0] OP_JIT  = 5'd8;
   localparam logic [4:0] OP_JIF  = 5'd9;
   localparam logic [4:0] OP_CALL = 5'd10;
   localparam logic [4:0] OP_RET  = 5'd11;
   localparam logic [4:0] OP_EQ   = 5'd12;
   localparam logic [4:0] OP_GT   = 5'd13;
   localparam logic [4:0] OP_GE   = 5'd14;
   localparam logic [4:0] OP_LT   = 5'd15;
   localparam logic [4:0] OP_LE   = 5'd16;
   localparam logic [4:0] OP_NE   = 5'd17;
   localparam logic [4:0] OP_STO  = 5'd18;
   localparam logic [4:0] OP_RCL  = 5'd19;
   localparam logic [4:0] OP_END  = 5'd20;
   localparam logic [4:0] OP_PRN  = 5'd21;
   localparam logic [4:0] OP_STL  = 5'd22;
   localparam logic [4:0] OP_RCE  = 5'd23;
   localparam logic [4:0] OP_ALC  = 5'd24;
   localparam logic [4:0] OP_FRE  = 5'd25;
   localparam logic [4:0] OP_ATR  = 5'd26;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_UNF   = 3'd1;
   localparam logic [2:0] ST_OVF   = 3'd2;
   localparam logic [2:0] ST_CALL  = 3'd3;
   localparam logic [2:0] ST_DIV0  = 3'd4;
   localparam logic [2:0] ST_ADDR  = 3'd5;
   localparam logic [2:0] ST_UNSUP = 3'd6;

   localparam logic [2:0] CSR_NUMBER_TAG = 3'd0;
   localparam logic [2:0] CSR_STEP_LIMIT = 3'd4;

endpackage

// ===== sv/smx_div.sv =====
module smx_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [32:0] rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff[31:0], quo_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         den_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule

// ===== sv/stack_machine_execute.sv =====
// Each request is accepted with its memory read, then executed and written back in
// S_EXEC, which waits while the response slot is full; a divide adds S_DIV for the
// shift-subtract divider, and a call adds S_WR2 for its second call-stack write.
// A new request is accepted only in S_IDLE, once the previous one is finished.
// Reset (synchronous, active high) clears counts, pc, frame base, step count,
// halt, registers and call-stack valid bits; no clearing pass is needed.
module stack_machine_execute (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // op[4:0], arg_tag[7:5], arg_value[39:8]
   input  logic [smx_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // next_ip[9:0], print_valid[10], print_tag[13:11], print_value[45:14],
   // halted[46], status[49:47], zero[55:50]
   output logic [smx_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int DAW = smx_pkg::DATA_AW;
   localparam int DCW = smx_pkg::DATA_CW;
   localparam int CAW = smx_pkg::CALL_AW;
   localparam int CCW = smx_pkg::CALL_CW;
   localparam int SAW = smx_pkg::STORE_AW;
   localparam int PW  = smx_pkg::PC_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_DIV  = 4'b0100,
      S_WR2  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]  number_tag_ff;
   logic [31:0] step_limit_ff;

   logic [DCW-1:0] data_count_ff, data_count_in;
   logic [CCW-1:0] call_top_ff, call_top_in;
   logic [CCW-1:0] frame_base_ff, frame_base_in;
   logic [PW-1:0]  pc_ff, pc_in;
   logic [31:0]    steps_ff, steps_in;
   logic           stopped_ff, stopped_in;

   logic [4:0]  op_ff;
   logic [2:0]  tag_ff;
   logic [31:0] val_ff;

   smx_pkg::cell_type dmem [smx_pkg::DATA_DEPTH];
   smx_pkg::cell_type cmem [smx_pkg::CALL_DEPTH];
   smx_pkg::cell_type smem [smx_pkg::STORE_DEPTH];
   logic [smx_pkg::CALL_DEPTH-1:0] cvalid_ff;

   smx_pkg::cell_type rd_a_ff, rd_b_ff, cs_a_ff, cs_b_ff, vs_ff;
   logic              cva_ff, cvb_ff;
   smx_pkg::cell_type cs_a, cs_b;

   logic [CAW-1:0]    pend_addr_ff, pend_addr_in;
   smx_pkg::cell_type pend_data_ff, pend_data_in;

   logic [smx_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff;

   logic        req_acc, out_free, commit;
   logic [4:0]  req_op;
   logic [31:0] req_val;
   logic [33:0] req_idx;
   logic [CAW-1:0] ca_addr;

   logic              dw_en, cw_en, sw_en;
   logic [DAW-1:0]    dw_addr;
   logic [CAW-1:0]    cw_addr;
   smx_pkg::cell_type dw_data, cw_data;

   logic        div_start, div_done;
   logic [31:0] div_q;

   logic        stop_pre, in_prog, in_store, tags_ok, take, need_div, use_pend;
   logic [PW-1:0]  next_ip;
   logic [31:0]    r, steps_next;
   logic [33:0]    idx;
   logic [2:0]     status;
   logic           pv;
   smx_pkg::cell_type pcell;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_op     = req_tdata[4:0];
   assign req_val    = req_tdata[39:8];
   assign req_idx    = {{2{req_val[31]}}, req_val} + 34'(frame_base_ff) - 34'd1;
   assign ca_addr    = (req_op == smx_pkg::OP_RET) ? CAW'(frame_base_ff - CCW'(1))
                                                   : req_idx[CAW-1:0];

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_a_ff <= dmem[DAW'(data_count_ff - DCW'(1))];
         rd_b_ff <= dmem[DAW'(data_count_ff - DCW'(2))];
         cs_a_ff <= cmem[ca_addr];
         cs_b_ff <= cmem[CAW'(frame_base_ff - CCW'(2))];
         cva_ff  <= cvalid_ff[ca_addr];
         cvb_ff  <= cvalid_ff[CAW'(frame_base_ff - CCW'(2))];
         vs_ff   <= smem[req_val[SAW-1:0]];
         op_ff   <= req_op;
         tag_ff  <= req_tdata[7:5];
         val_ff  <= req_val;
      end
      if (dw_en) dmem[dw_addr] <= dw_data;
      if (cw_en) cmem[cw_addr] <= cw_data;
      if (sw_en) smem[val_ff[SAW-1:0]] <= rd_a_ff;
   end

   assign cs_a = cva_ff ? cs_a_ff : '0;
   assign cs_b = cvb_ff ? cs_b_ff : '0;

   smx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_b_ff.val),
      .divisor  (rd_a_ff.val),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      stop_pre = stopped_ff || (step_limit_ff != '0 && steps_ff >= step_limit_ff);
      in_prog  = !val_ff[31] && val_ff < 32'(smx_pkg::PROG_DEPTH);
      in_store = !val_ff[31] && val_ff < 32'(smx_pkg::STORE_DEPTH);
      tags_ok  = rd_a_ff.tag == number_tag_ff && rd_b_ff.tag == number_tag_ff;
      take     = (rd_a_ff.val != '0) == (op_ff == smx_pkg::OP_JIT);
      need_div = !stop_pre && op_ff == smx_pkg::OP_DIV && data_count_ff >= DCW'(2)
                 && tags_ok && rd_a_ff.val != '0;
      next_ip  = (pc_ff == PW'(smx_pkg::PROG_DEPTH - 1)) ? '0 : pc_ff + PW'(1);
      idx      = '0;
      r        = '0;
      status   = smx_pkg::ST_OK;
      pv       = 1'b0;
      pcell    = '0;
      use_pend = 1'b0;
      dw_en    = 1'b0;
      dw_addr  = DAW'(data_count_ff);
      dw_data  = '0;
      cw_en    = 1'b0;
      cw_addr  = CAW'(call_top_ff);
      cw_data  = '0;
      sw_en    = 1'b0;
      data_count_in = data_count_ff;
      call_top_in   = call_top_ff;
      frame_base_in = frame_base_ff;
      stopped_in    = stopped_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;

      unique case (op_ff)
         smx_pkg::OP_ADD: r = rd_b_ff.val + rd_a_ff.val;
         smx_pkg::OP_SUB: r = rd_b_ff.val - rd_a_ff.val;
         smx_pkg::OP_MUL: r = 32'(rd_b_ff.val * rd_a_ff.val);
         smx_pkg::OP_DIV: r = div_q;
         smx_pkg::OP_EQ:  r = 32'($signed(rd_b_ff.val) == $signed(rd_a_ff.val));
         smx_pkg::OP_GT:  r = 32'($signed(rd_b_ff.val) >  $signed(rd_a_ff.val));
         smx_pkg::OP_GE:  r = 32'($signed(rd_b_ff.val) >= $signed(rd_a_ff.val));
         smx_pkg::OP_LT:  r = 32'($signed(rd_b_ff.val) <  $signed(rd_a_ff.val));
         smx_pkg::OP_LE:  r = 32'($signed(rd_b_ff.val) <= $signed(rd_a_ff.val));
         default:         r = 32'($signed(rd_b_ff.val) != $signed(rd_a_ff.val));
      endcase

      if (stop_pre) begin
         stopped_in = 1'b1;
         next_ip    = pc_ff;
      end else begin
         unique case (op_ff)
            smx_pkg::OP_PUSH: begin
               if (data_count_ff >= DCW'(smx_pkg::DATA_DEPTH)) status = smx_pkg::ST_OVF;
               else begin
                  dw_en = 1'b1;
                  dw_data = '{tag: tag_ff, val: val_ff};
                  data_count_in = data_count_ff + DCW'(1);
               end
            end
            smx_pkg::OP_POP: begin
               if (data_count_ff < DCW'(1)) status = smx_pkg::ST_UNF;
               else data_count_in = data_count_ff - DCW'(1);
            end
            smx_pkg::OP_DUP: begin
               if (data_count_ff < DCW'(1)) status = smx_pkg::ST_UNF;
               else if (data_count_ff >= DCW'(smx_pkg::DATA_DEPTH)) status = smx_pkg::ST_OVF;
               else begin
                  dw_en = 1'b1;
                  dw_data = rd_a_ff;
                  data_count_in = data_count_ff + DCW'(1);
               end
            end
            smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV,
            smx_pkg::OP_EQ, smx_pkg::OP_GT, smx_pkg::OP_GE, smx_pkg::OP_LT,
            smx_pkg::OP_LE, smx_pkg::OP_NE: begin
               if (data_count_ff < DCW'(2)) status = smx_pkg::ST_UNF;
               else if (!tags_ok) data_count_in = data_count_ff - DCW'(2);
               else if (op_ff == smx_pkg::OP_DIV && rd_a_ff.val == '0) begin
                  status = smx_pkg::ST_DIV0;
               end else begin
                  dw_en = 1'b1;
                  dw_addr = DAW'(data_count_ff - DCW'(2));
                  dw_data = '{tag: number_tag_ff, val: r};
                  data_count_in = data_count_ff - DCW'(1);
               end
            end
            smx_pkg::OP_JMP: begin
               if (!in_prog) status = smx_pkg::ST_ADDR;
               else next_ip = val_ff[PW-1:0];
            end
            smx_pkg::OP_JIT, smx_pkg::OP_JIF: begin
               if (data_count_ff < DCW'(1)) status = smx_pkg::ST_UNF;
               else if (take && !in_prog) status = smx_pkg::ST_ADDR;
               else begin
                  data_count_in = data_count_ff - DCW'(1);
                  if (take) next_ip = val_ff[PW-1:0];
               end
            end
            smx_pkg::OP_CALL: begin
               if (call_top_ff > CCW'(smx_pkg::CALL_DEPTH - 2)) status = smx_pkg::ST_CALL;
               else if (!in_prog) status = smx_pkg::ST_ADDR;
               else begin
                  cw_en = 1'b1;
                  cw_data = '{tag: 3'd0, val: 32'(pc_ff)};
                  use_pend = 1'b1;
                  pend_addr_in = CAW'(call_top_ff + CCW'(1));
                  pend_data_in = '{tag: 3'd0, val: 32'(frame_base_ff)};
                  call_top_in = call_top_ff + CCW'(2);
                  frame_base_in = call_top_ff + CCW'(2);
                  next_ip = val_ff[PW-1:0];
               end
            end
            smx_pkg::OP_RET: begin
               if (frame_base_ff < CCW'(2) || frame_base_ff > CCW'(smx_pkg::CALL_DEPTH)
                   || cs_a.val > 32'(smx_pkg::CALL_DEPTH)
                   || cs_b.val >= 32'(smx_pkg::PROG_DEPTH)) begin
                  status = smx_pkg::ST_CALL;
               end else begin
                  call_top_in = frame_base_ff - CCW'(2);
                  frame_base_in = cs_a.val[CCW-1:0];
                  next_ip = (cs_b.val[PW-1:0] == PW'(smx_pkg::PROG_DEPTH - 1))
                            ? '0 : cs_b.val[PW-1:0] + PW'(1);
               end
            end
            smx_pkg::OP_STO: begin
               if (!in_store) status = smx_pkg::ST_ADDR;
               else if (data_count_ff < DCW'(1)) status = smx_pkg::ST_UNF;
               else begin
                  data_count_in = data_count_ff - DCW'(1);
                  sw_en = 1'b1;
               end
            end
            smx_pkg::OP_RCL: begin
               if (!in_store) status = smx_pkg::ST_ADDR;
               else if (data_count_ff >= DCW'(smx_pkg::DATA_DEPTH)) status = smx_pkg::ST_OVF;
               else begin
                  dw_en = 1'b1;
                  dw_data = vs_ff;
                  data_count_in = data_count_ff + DCW'(1);
               end
            end
            smx_pkg::OP_END: begin
               stopped_in = 1'b1;
               next_ip = pc_ff;
            end
            smx_pkg::OP_PRN: begin
               if (data_count_ff < DCW'(1)) status = smx_pkg::ST_UNF;
               else begin
                  data_count_in = data_count_ff - DCW'(1);
                  pv = 1'b1;
                  pcell = rd_a_ff;
               end
            end
            smx_pkg::OP_STL, smx_pkg::OP_RCE: begin
               idx = {{2{val_ff[31]}}, val_ff} + 34'(frame_base_ff) - 34'd1;
               if (idx[33] || idx >= 34'(smx_pkg::CALL_DEPTH)) status = smx_pkg::ST_ADDR;
               else if (op_ff == smx_pkg::OP_STL) begin
                  if (data_count_ff < DCW'(1)) status = smx_pkg::ST_UNF;
                  else begin
                     data_count_in = data_count_ff - DCW'(1);
                     cw_en = 1'b1;
                     cw_addr = idx[CAW-1:0];
                     cw_data = rd_a_ff;
                  end
               end else begin
                  if (data_count_ff >= DCW'(smx_pkg::DATA_DEPTH)) status = smx_pkg::ST_OVF;
                  else begin
                     dw_en = 1'b1;
                     dw_data = cs_a;
                     data_count_in = data_count_ff + DCW'(1);
                  end
               end
            end
            smx_pkg::OP_ALC, smx_pkg::OP_FRE: begin
               if (op_ff == smx_pkg::OP_ALC) idx = 34'(call_top_ff) + {{2{val_ff[31]}}, val_ff};
               else idx = 34'(call_top_ff) - {{2{val_ff[31]}}, val_ff};
               if (idx[33] || idx > 34'(smx_pkg::CALL_DEPTH)) status = smx_pkg::ST_CALL;
               else call_top_in = idx[CCW-1:0];
            end
            smx_pkg::OP_ATR: ;
            default: status = smx_pkg::ST_UNSUP;
         endcase
      end

      steps_next = stop_pre ? steps_ff
                 : (steps_ff == '1) ? steps_ff : steps_ff + 32'd1;
      if (!stop_pre && step_limit_ff != '0 && steps_next >= step_limit_ff) stopped_in = 1'b1;

      commit = out_free && ((state_ff == S_EXEC && !need_div)
                            || (state_ff == S_DIV && div_done));
      div_start = state_ff == S_EXEC && need_div;
      if (!commit) begin
         dw_en = 1'b0;
         cw_en = 1'b0;
         sw_en = 1'b0;
      end
      if (state_ff == S_WR2) begin
         cw_en   = 1'b1;
         cw_addr = pend_addr_ff;
         cw_data = pend_data_ff;
      end

      rsp_data_in = {6'd0, status, stopped_in, pcell.val, pcell.tag, pv, next_ip};

      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_acc) state_in = S_EXEC;
         S_EXEC: begin
            if (need_div) state_in = S_DIV;
            else if (commit) state_in = use_pend ? S_WR2 : S_IDLE;
         end
         S_DIV:  if (commit) state_in = S_IDLE;
         S_WR2:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign pc_in    = next_ip;
   assign steps_in = steps_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         data_count_ff <= '0;
         call_top_ff   <= '0;
         frame_base_ff <= '0;
         pc_ff         <= '0;
         steps_ff      <= '0;
         stopped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cvalid_ff     <= '0;
         number_tag_ff <= '0;
         step_limit_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            data_count_ff <= data_count_in;
            call_top_ff   <= call_top_in;
            frame_base_ff <= frame_base_in;
            pc_ff         <= pc_in;
            steps_ff      <= steps_in;
            stopped_ff    <= stopped_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cw_en) cvalid_ff[cw_addr] <= 1'b1;
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr == smx_pkg::CSR_NUMBER_TAG) number_tag_ff <= csr_pwdata[2:0];
            else if (csr_paddr == smx_pkg::CSR_STEP_LIMIT) step_limit_ff <= csr_pwdata;
         end
      end
      if (commit) begin
         rsp_data_ff  <= rsp_data_in;
         pend_addr_ff <= pend_addr_in;
         pend_data_ff <= pend_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == smx_pkg::CSR_NUMBER_TAG) ? {29'd0, number_tag_ff}
                     : (csr_paddr == smx_pkg::CSR_STEP_LIMIT) ? step_limit_ff : 32'd0;

`ifndef ASSERT_OFF
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      data_count_ff <= DCW'(smx_pkg::DATA_DEPTH))
      else $error("data count beyond depth");
   a_call_top: assert property (@(posedge clock) disable iff (reset)
      call_top_ff <= CCW'(smx_pkg::CALL_DEPTH))
      else $error("call top beyond depth");
   a_stopped_holds: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("halt released without reset");
   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      commit |-> out_free)
      else $error("result overwritten while waiting");
`endif

endmodule
